@@ src/drr_pkg.sv @@
`default_nettype none

package drr_pkg;

   localparam int CHAN_W    = 5;
   localparam int COUNT_W   = 6;
   localparam int BOUND_W   = 31;
   localparam int GAP_W     = 32;
   localparam int DEFICIT_W = 32;
   localparam int WEIGHT_W  = 24;
   localparam int TIME_W    = 48;
   localparam int KIND_W    = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAN_W-1:0]  FIRST_RESET = '0;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;
   localparam logic [BOUND_W-1:0] BOUND_RESET = 31'd655360;
   localparam logic [GAP_W-1:0]   GAP_RESET   = 32'd10000;

   // one in q16.16
   localparam logic signed [DEFICIT_W:0] Q_ONE = 33'sd65536;
   localparam logic [DEFICIT_W-1:0] DEFICIT_MIN = 32'h8000_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET   = 2'd0,
      KIND_ACC   = 2'd1,
      KIND_PICK  = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_FIRST_CHANNEL = 2'd0,
      REG_CHANNEL_COUNT = 2'd1,
      REG_DEFICIT_BOUND = 2'd2,
      REG_MAX_GAP       = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  first;
      logic [COUNT_W-1:0] count;
      logic [BOUND_W-1:0] bound;
      logic [GAP_W-1:0]   max_gap;
   } cfg_type;

   typedef struct packed {
      kind_type op;
      logic     set_wr;
      logic     init;
      logic     sub;
      logic     issue;
      logic     commit;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic off_big;
      logic last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

@@ src/drr_ifs.sv @@
`default_nettype none

interface drr_req_if;
   logic                          valid;
   logic                          ready;
   logic [drr_pkg::KIND_W-1:0]    kind;
   logic [drr_pkg::CHAN_W-1:0]    channel;
   logic [drr_pkg::WEIGHT_W-1:0]  weight;
   logic                          active;
   logic [drr_pkg::TIME_W-1:0]    last_service;
   logic [drr_pkg::TIME_W-1:0]    now;

   modport source (output valid, kind, channel, weight, active, last_service, now,
                   input ready);
   modport sink (input valid, kind, channel, weight, active, last_service, now,
                 output ready);
endinterface

interface drr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       result_kind;
   logic                       found;
   logic [drr_pkg::CHAN_W-1:0] chosen;

   modport source (output valid, result_kind, found, chosen, input ready);
   modport sink (input valid, result_kind, found, chosen, output ready);
endinterface

`default_nettype wire

@@ src/deficit_round_robin_scheduler_top.sv @@
`default_nettype none

// set, accumulate, pick and query; span = channels in [first_channel, min(count, MAX_CHANNELS)).
// pick resumes one past the cursor, folding the start back into the span first; query scans the span.
// one entry read per cycle from the table memories sets the rate; one transaction at a time.
// responses sit in an output register, the next request is taken while one waits.
// synchronous active-high reset: all entries read as zero, cursor 0, registers to defaults.
module deficit_round_robin_scheduler_top #(
   parameter int MAX_CHANNELS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   drr_req_if.sink                              req_ch,
   drr_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [drr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [drr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [drr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   drr_pkg::cfg_type    cfg;
   drr_pkg::cmd_type    cmd;
   drr_pkg::status_type status;

   drr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   drr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (drr_pkg::kind_type'(req_ch.kind)),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   drr_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_channel      (req_ch.channel),
      .req_weight       (req_ch.weight),
      .req_active       (req_ch.active),
      .req_last_service (req_ch.last_service),
      .req_now          (req_ch.now),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_result_kind  (rsp_ch.result_kind),
      .rsp_found        (rsp_ch.found),
      .rsp_chosen       (rsp_ch.chosen)
   );

endmodule

`default_nettype wire

@@ src/drr_ram.sv @@
`default_nettype none

module drr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]                              wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic      [WIDTH-1:0]                              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/drr_csr.sv @@
`default_nettype none

module drr_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [drr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [drr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [drr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output drr_pkg::cfg_type                      cfg
);
   drr_pkg::cfg_type       cfg_ff, cfg_in;
   drr_pkg::reg_index_type sel;
   logic                   wr;

   assign sel = drr_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (sel)
            drr_pkg::REG_FIRST_CHANNEL: cfg_in.first = csr_pwdata[drr_pkg::CHAN_W-1:0];
            drr_pkg::REG_CHANNEL_COUNT: cfg_in.count = csr_pwdata[drr_pkg::COUNT_W-1:0];
            drr_pkg::REG_DEFICIT_BOUND: cfg_in.bound = csr_pwdata[drr_pkg::BOUND_W-1:0];
            drr_pkg::REG_MAX_GAP:       cfg_in.max_gap = csr_pwdata[drr_pkg::GAP_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first   <= drr_pkg::FIRST_RESET;
         cfg_ff.count   <= drr_pkg::COUNT_RESET;
         cfg_ff.bound   <= drr_pkg::BOUND_RESET;
         cfg_ff.max_gap <= drr_pkg::GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (sel)
         drr_pkg::REG_FIRST_CHANNEL: csr_prdata = 32'(cfg_ff.first);
         drr_pkg::REG_CHANNEL_COUNT: csr_prdata = 32'(cfg_ff.count);
         drr_pkg::REG_DEFICIT_BOUND: csr_prdata = 32'(cfg_ff.bound);
         drr_pkg::REG_MAX_GAP:       csr_prdata = cfg_ff.max_gap;
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

@@ src/drr_ctrl.sv @@
`default_nettype none

module drr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  drr_pkg::kind_type         req_kind,
   output logic                      req_ready,
   input  drr_pkg::status_type       status,
   output drr_pkg::cmd_type          cmd
);
   drr_pkg::state_type state_ff, state_in;
   drr_pkg::kind_type  op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         drr_pkg::ST_IDLE: begin
            if (req_valid && req_kind != drr_pkg::KIND_SET) begin
               op_in    = req_kind;
               state_in = drr_pkg::ST_PREP;
            end
         end
         drr_pkg::ST_PREP: begin
            if (status.empty) begin
               state_in = (op_ff == drr_pkg::KIND_ACC) ? drr_pkg::ST_IDLE : drr_pkg::ST_RESP;
            end else if (!status.off_big) begin
               state_in = drr_pkg::ST_SCAN;
            end
         end
         drr_pkg::ST_SCAN: begin
            if (status.last) begin
               state_in = drr_pkg::ST_DRAIN;
            end
         end
         drr_pkg::ST_DRAIN: begin
            case (op_ff)
               drr_pkg::KIND_PICK:  state_in = drr_pkg::ST_COMMIT;
               drr_pkg::KIND_QUERY: state_in = drr_pkg::ST_RESP;
               default:             state_in = drr_pkg::ST_IDLE;
            endcase
         end
         drr_pkg::ST_COMMIT: state_in = drr_pkg::ST_RESP;
         drr_pkg::ST_RESP: begin
            if (!status.rsp_busy) begin
               state_in = drr_pkg::ST_IDLE;
            end
         end
         default: state_in = drr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.op    = req_kind;
      req_ready = 1'b0;
      case (state_ff)
         drr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == drr_pkg::KIND_SET) begin
                  cmd.set_wr = 1'b1;
               end else begin
                  cmd.init = 1'b1;
               end
            end
         end
         drr_pkg::ST_PREP:   cmd.sub = !status.empty && status.off_big;
         drr_pkg::ST_SCAN:   cmd.issue = 1'b1;
         drr_pkg::ST_COMMIT: cmd.commit = 1'b1;
         drr_pkg::ST_RESP:   cmd.load_rsp = !status.rsp_busy;
         default:            cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drr_pkg::ST_IDLE;
         op_ff    <= drr_pkg::KIND_SET;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   a_issue_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> state_ff == drr_pkg::ST_SCAN && op_ff != drr_pkg::KIND_SET)
      else $error("scan read issued outside a scan");

   a_commit_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(state_ff) == drr_pkg::ST_DRAIN && op_ff == drr_pkg::KIND_PICK)
      else $error("pick commit without a finished scan");

endmodule

`default_nettype wire

@@ src/drr_dp.sv @@
`default_nettype none

module drr_dp #(
   parameter int MAX_CHANNELS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  drr_pkg::cfg_type                       cfg,
   input  drr_pkg::cmd_type                       cmd,
   output drr_pkg::status_type                    status,
   input  wire logic [drr_pkg::CHAN_W-1:0]        req_channel,
   input  wire logic [drr_pkg::WEIGHT_W-1:0]      req_weight,
   input  wire logic                              req_active,
   input  wire logic [drr_pkg::TIME_W-1:0]        req_last_service,
   input  wire logic [drr_pkg::TIME_W-1:0]        req_now,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_result_kind,
   output logic                                   rsp_found,
   output logic      [drr_pkg::CHAN_W-1:0]        rsp_chosen
);
   localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
   localparam int SW      = (CNT_W > drr_pkg::COUNT_W) ? CNT_W : drr_pkg::COUNT_W;
   localparam int DW      = drr_pkg::DEFICIT_W;
   localparam int TW      = drr_pkg::TIME_W;
   localparam int PARAM_W = drr_pkg::WEIGHT_W + 1 + TW;

   // span arithmetic
   logic [SW-1:0] max_ext, count_ext, first_ext, n_eff, span, cursor_ext, chan_ext;
   logic [SW-1:0] scan_sum, off_next, best_ext;
   logic          chan_ok;

   logic [SW-1:0]             off_ff, off_in, left_ff, left_in;
   logic                      have_ff, have_in;
   logic [IDX_W-1:0]          best_ff, best_in, cursor_ff, cursor_in;
   logic signed [DW-1:0]      best_d_ff, best_d_in;
   drr_pkg::kind_type         op_ff, op_in;
   logic [TW-1:0]             now_ff, now_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]          rd_addr_ff, rd_addr_in;
   logic [MAX_CHANNELS-1:0]   pvalid_ff, pvalid_in, dvalid_ff, dvalid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_found_ff;
   logic [drr_pkg::CHAN_W-1:0] rsp_chosen_ff;

   // entry read back
   logic [PARAM_W-1:0]        p_raw, p_rd;
   logic [DW-1:0]             d_raw;
   logic signed [DW-1:0]      d_rd;
   logic [drr_pkg::WEIGHT_W-1:0] e_weight;
   logic                      e_active;
   logic [TW-1:0]             e_time, gap;

   logic signed [DW+1:0]      acc_sum, bpos, bneg;
   logic signed [DW-1:0]      acc_val;
   logic signed [DW:0]        pick_diff;
   logic [DW-1:0]             pick_val;

   logic                      pwe, dwe;
   logic [IDX_W-1:0]          dwaddr;
   logic [DW-1:0]             dwdata;

   assign max_ext    = SW'(MAX_CHANNELS);
   assign count_ext  = SW'(cfg.count);
   assign first_ext  = SW'(cfg.first);
   assign n_eff      = (count_ext > max_ext) ? max_ext : count_ext;
   assign span       = n_eff - first_ext;
   assign cursor_ext = SW'(cursor_ff);
   assign chan_ext   = SW'(req_channel);
   assign chan_ok    = chan_ext < max_ext;
   assign scan_sum   = first_ext + off_ff;
   assign off_next   = (off_ff + SW'(1) == span) ? '0 : off_ff + SW'(1);
   assign best_ext   = SW'(best_ff);

   assign status.empty    = n_eff <= first_ext;
   assign status.off_big  = off_ff >= span;
   assign status.last     = left_ff == SW'(1);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign p_rd     = pvalid_ff[rd_addr_ff] ? p_raw : '0;
   assign d_rd     = dvalid_ff[rd_addr_ff] ? $signed(d_raw) : '0;
   assign e_weight = p_rd[PARAM_W-1 -: drr_pkg::WEIGHT_W];
   assign e_active = p_rd[TW];
   assign e_time   = p_rd[TW-1:0];
   assign gap      = now_ff - e_time;

   // accumulate with clamp to plus or minus bound; an inactive channel is set to zero
   always_comb begin
      bpos    = $signed({3'b000, cfg.bound});
      bneg    = -bpos;
      acc_sum = e_active ? ({{2{d_rd[DW-1]}}, d_rd} + $signed({10'b0, e_weight})) : '0;
      if (acc_sum > bpos) begin
         acc_val = bpos[DW-1:0];
      end else if (acc_sum < bneg) begin
         acc_val = bneg[DW-1:0];
      end else begin
         acc_val = acc_sum[DW-1:0];
      end
   end

   // subtract one with saturation at the most negative value
   assign pick_diff = {best_d_ff[DW-1], best_d_ff} - drr_pkg::Q_ONE;
   assign pick_val  = (pick_diff[DW] != pick_diff[DW-1]) ? drr_pkg::DEFICIT_MIN
                                                         : pick_diff[DW-1:0];

   assign pwe    = cmd.set_wr && chan_ok;
   assign dwe    = (rd_vld_ff && op_ff == drr_pkg::KIND_ACC) || (cmd.commit && have_ff);
   assign dwaddr = cmd.commit ? best_ff : rd_addr_ff;
   assign dwdata = cmd.commit ? pick_val : acc_val;

   drr_ram #(.WIDTH(PARAM_W), .DEPTH(MAX_CHANNELS)) u_param_ram (
      .clock (clock),
      .we    (pwe),
      .waddr (chan_ext[IDX_W-1:0]),
      .wdata ({req_weight, req_active, req_last_service}),
      .raddr (scan_sum[IDX_W-1:0]),
      .rdata (p_raw)
   );

   drr_ram #(.WIDTH(DW), .DEPTH(MAX_CHANNELS)) u_deficit_ram (
      .clock (clock),
      .we    (dwe),
      .waddr (dwaddr),
      .wdata (dwdata),
      .raddr (scan_sum[IDX_W-1:0]),
      .rdata (d_raw)
   );

   always_comb begin
      off_in       = off_ff;
      left_in      = left_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      cursor_in    = cursor_ff;
      rd_vld_in    = 1'b0;
      rd_addr_in   = rd_addr_ff;
      pvalid_in    = pvalid_ff;
      dvalid_in    = dvalid_ff;
      rsp_valid_in = rsp_valid_ff;

      if (pwe) begin
         pvalid_in[chan_ext[IDX_W-1:0]] = 1'b1;
      end
      if (dwe) begin
         dvalid_in[dwaddr] = 1'b1;
      end

      if (cmd.init) begin
         op_in   = cmd.op;
         now_in  = req_now;
         have_in = 1'b0;
         left_in = span;
         // pick resumes one past the cursor, else the scan starts at the first channel
         if (cmd.op == drr_pkg::KIND_PICK && cursor_ext >= first_ext) begin
            off_in = cursor_ext - first_ext + SW'(1);
         end else begin
            off_in = '0;
         end
      end

      if (cmd.sub) begin
         off_in = off_ff - span;
      end

      if (cmd.issue) begin
         rd_vld_in  = 1'b1;
         rd_addr_in = scan_sum[IDX_W-1:0];
         left_in    = left_ff - SW'(1);
         off_in     = off_next;
      end

      if (rd_vld_ff) begin
         case (op_ff)
            drr_pkg::KIND_PICK: begin
               if (e_active && (!have_ff || d_rd > best_d_ff)) begin
                  have_in   = 1'b1;
                  best_in   = rd_addr_ff;
                  best_d_in = d_rd;
               end
            end
            drr_pkg::KIND_QUERY: begin
               if (e_active && e_time != '0 && gap > TW'(cfg.max_gap) && !have_ff) begin
                  have_in = 1'b1;
                  best_in = rd_addr_ff;
               end
            end
            default: have_in = have_ff;
         endcase
      end

      if (cmd.commit && have_ff) begin
         cursor_in = best_ff;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         op_ff        <= drr_pkg::KIND_SET;
         cursor_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         pvalid_ff    <= '0;
         dvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         off_ff       <= '0;
         left_ff      <= '0;
      end else begin
         have_ff      <= have_in;
         op_ff        <= op_in;
         cursor_ff    <= cursor_in;
         rd_vld_ff    <= rd_vld_in;
         pvalid_ff    <= pvalid_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         off_ff       <= off_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff    <= best_in;
      best_d_ff  <= best_d_in;
      now_ff     <= now_in;
      rd_addr_ff <= rd_addr_in;
      if (cmd.load_rsp) begin
         rsp_kind_ff   <= (op_ff == drr_pkg::KIND_QUERY);
         rsp_found_ff  <= have_ff;
         rsp_chosen_ff <= have_ff ? best_ext[drr_pkg::CHAN_W-1:0] : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_chosen      = rsp_chosen_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> scan_sum < n_eff && scan_sum >= first_ext)
      else $error("scan address outside the channel range");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rd_vld_ff)
      else $error("pick commit collides with a scan write");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten before it was taken");

   a_found_active: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && have_ff |-> pvalid_ff[best_ff])
      else $error("picked channel was never set");

endmodule

`default_nettype wire
